>>> hw/rtl/vtr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the virtual texture residency block.
// Used by vtr_ctrl, vtr_datapath and the top module under hw/rtl; depends on nothing.
package vtr_pkg;

  localparam int unsigned MipLevels = 8;
  localparam int unsigned VirtSide  = 128;
  localparam int unsigned AtlasSide = 8;

  localparam int unsigned SlotCount = AtlasSide * AtlasSide;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned LvlW      = 4;   // covers up to 16 levels
  localparam int unsigned SideW     = 13;  // holds 4096

  function automatic int unsigned table_depth();
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < MipLevels; k++) begin
      acc += (VirtSide >> k) * (VirtSide >> k);
    end
    return acc;
  endfunction

  localparam int unsigned TableDepth = table_depth();
  localparam int unsigned IdxW       = $clog2(TableDepth);

  typedef enum logic [1:0] {
    ActFeedback = 2'd0,
    ActComplete = 2'd1,
    ActLookup   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    StRequested = 3'd0,
    StKnown     = 3'd1,
    StRange     = 3'd2,
    StPlaced    = 3'd3,
    StFull      = 3'd4,
    StLookup    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SlotNone,
    SlotEntry,
    SlotChosen
  } slot_src_e;

  typedef enum logic [2:0] {
    PtNone,
    PtClear,
    PtFeedback,
    PtHit,
    PtFull,
    PtVictim,
    PtPlace
  } pt_wr_e;

  typedef enum logic [3:0] {
    SClear,
    SIdle,
    SIdx,
    SRd,
    SUse,
    SFree,
    SOwnRd,
    SOwnIdx,
    SPtRd,
    SCmp,
    SEvict,
    SPlace,
    SOut
  } state_e;

  typedef struct packed {
    logic [31:0]      last_use;
    logic [SlotW-1:0] slot;
    logic             resident;
    logic             pending;
  } page_entry_t;

  typedef struct packed {
    logic      load;
    logic      calc_main;
    logic      calc_owner;
    pt_wr_e    pt_wr;
    logic      cur_keep;
    logic      lvl_inc;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      choose_cnt;
    logic      choose_best;
    logic      best_upd;
    logic      res_set;
    status_e   res_status;
    slot_src_e res_slot;
    logic      res_found;
    logic      out_load;
  } vtr_cmd_t;

  typedef struct packed {
    logic    clr_last;
    action_e action;
    logic    in_range;
    logic    first_lvl;
    logic    lvl_last;
    logic    resident;
    logic    pending;
    logic    taken_cur;
    logic    cnt_last;
    logic    older;
    logic    best_found;
    logic    out_free;
  } vtr_stat_t;

  function automatic logic [SideW-1:0] side_at(input logic [LvlW-1:0] m);
    return SideW'(VirtSide >> m);
  endfunction

  function automatic logic [IdxW-1:0] level_base(input logic [LvlW-1:0] m);
    logic [IdxW-1:0] acc;
    acc = '0;
    for (int unsigned k = 0; k < MipLevels; k++) begin
      if (LvlW'(k) < m) begin
        acc += IdxW'((VirtSide >> k) * (VirtSide >> k));
      end
    end
    return acc;
  endfunction

endpackage

>>> hw/rtl/vtr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module vtr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/vtr_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the residency block: clear pass, decode, slot scans, output.
// Depends on vtr_pkg.
module vtr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vtr_pkg::vtr_stat_t stat_i,
  output vtr_pkg::vtr_cmd_t  cmd_o
);

  vtr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vtr_pkg::SClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.pt_wr      = vtr_pkg::PtNone;
    cmd_o.res_status = vtr_pkg::StRequested;
    cmd_o.res_slot   = vtr_pkg::SlotNone;
    in_ready_o = 1'b0;
    unique case (state_q)
      vtr_pkg::SClear: begin
        cmd_o.pt_wr = vtr_pkg::PtClear;
        if (stat_i.clr_last) state_d = vtr_pkg::SIdle;
      end
      vtr_pkg::SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = vtr_pkg::SIdx;
        end
      end
      vtr_pkg::SIdx: begin
        // unused action code: drop silently
        if (stat_i.action != vtr_pkg::ActFeedback && stat_i.action != vtr_pkg::ActComplete
            && stat_i.action != vtr_pkg::ActLookup) begin
          state_d = vtr_pkg::SIdle;
        end else begin
          cmd_o.calc_main = 1'b1;
          state_d         = vtr_pkg::SRd;
        end
      end
      vtr_pkg::SRd: state_d = vtr_pkg::SUse;
      vtr_pkg::SUse: begin
        state_d = vtr_pkg::SOut;
        if (!stat_i.in_range && stat_i.first_lvl) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = vtr_pkg::StRange;
        end else begin
          unique case (stat_i.action)
            vtr_pkg::ActFeedback: begin
              cmd_o.pt_wr      = vtr_pkg::PtFeedback;
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = stat_i.resident ? vtr_pkg::StKnown
                               : (stat_i.pending ? vtr_pkg::StKnown : vtr_pkg::StRequested);
            end
            vtr_pkg::ActComplete: begin
              cmd_o.cur_keep = 1'b1;
              if (stat_i.resident) begin
                cmd_o.pt_wr      = vtr_pkg::PtHit;
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = vtr_pkg::StKnown;
                cmd_o.res_slot   = vtr_pkg::SlotEntry;
              end else begin
                cmd_o.cnt_clr = 1'b1;
                state_d       = vtr_pkg::SFree;
              end
            end
            default: begin
              if (stat_i.in_range && stat_i.resident) begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = vtr_pkg::StLookup;
                cmd_o.res_slot   = vtr_pkg::SlotEntry;
                cmd_o.res_found  = 1'b1;
              end else if (!stat_i.lvl_last) begin
                cmd_o.lvl_inc = 1'b1;
                state_d       = vtr_pkg::SIdx;
              end else begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = vtr_pkg::StLookup;
              end
            end
          endcase
        end
      end
      vtr_pkg::SFree: begin
        if (!stat_i.taken_cur) begin
          cmd_o.choose_cnt = 1'b1;
          state_d          = vtr_pkg::SPlace;
        end else if (stat_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = vtr_pkg::SOwnRd;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      vtr_pkg::SOwnRd:  state_d = vtr_pkg::SOwnIdx;
      vtr_pkg::SOwnIdx: begin
        cmd_o.calc_owner = 1'b1;
        state_d          = vtr_pkg::SPtRd;
      end
      vtr_pkg::SPtRd: state_d = vtr_pkg::SCmp;
      vtr_pkg::SCmp: begin
        cmd_o.best_upd = stat_i.older;
        if (stat_i.cnt_last) begin
          state_d = vtr_pkg::SEvict;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = vtr_pkg::SOwnRd;
        end
      end
      vtr_pkg::SEvict: begin
        if (stat_i.best_found) begin
          cmd_o.pt_wr       = vtr_pkg::PtVictim;
          cmd_o.choose_best = 1'b1;
          state_d           = vtr_pkg::SPlace;
        end else begin
          cmd_o.pt_wr      = vtr_pkg::PtFull;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = vtr_pkg::StFull;
          state_d          = vtr_pkg::SOut;
        end
      end
      vtr_pkg::SPlace: begin
        cmd_o.pt_wr      = vtr_pkg::PtPlace;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = vtr_pkg::StPlaced;
        cmd_o.res_slot   = vtr_pkg::SlotChosen;
        state_d          = vtr_pkg::SOut;
      end
      vtr_pkg::SOut: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = vtr_pkg::SIdle;
        end
      end
      default: state_d = vtr_pkg::SIdle;
    endcase
  end

endmodule

>>> hw/rtl/vtr_datapath.sv
`timescale 1ns / 1ps
// Datapath: page table and slot owner memories, index unit, LRU scan, results.
// Depends on vtr_pkg and vtr_ram.
module vtr_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vtr_pkg::vtr_cmd_t  cmd_i,
  output vtr_pkg::vtr_stat_t stat_o,
  input  logic [1:0]         action_i,
  input  logic [31:0]        page_key_i,
  input  logic [31:0]        frame_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [5:0]         slot_index_o,
  output logic [2:0]         slot_col_o,
  output logic [2:0]         slot_row_o,
  output logic [2:0]         found_mip_o,
  output logic               entry_valid_o,
  output logic               evicted_o,
  output logic [31:0]        evicted_key_o,
  output logic [6:0]         resident_pages_o
);

  localparam int unsigned SlotW = vtr_pkg::SlotW;
  localparam int unsigned IdxW  = vtr_pkg::IdxW;
  localparam int unsigned EntW  = $bits(vtr_pkg::page_entry_t);

  // item registers
  logic [1:0]  action_q;
  logic [31:0] key_q, frame_q;
  logic [7:0]  lvl_q;

  // index unit
  logic [IdxW-1:0] idx_q, cur_idx_q, clr_q;
  logic            in_range_q;
  logic [7:0]      c_mip;
  logic [11:0]     c_col, c_row;
  logic [3:0]      c_sh;
  logic [vtr_pkg::LvlW-1:0]  c_lvl;
  logic [vtr_pkg::SideW-1:0] c_side;
  logic            c_ok;
  logic [IdxW-1:0] c_idx;

  // memories
  vtr_pkg::page_entry_t pt_rd, pt_wd, ent_q, best_ent_q;
  logic [EntW-1:0]      pt_rdata;
  logic                 pt_we;
  logic [IdxW-1:0]      pt_waddr;
  logic [31:0]          own_rdata;

  // slot bookkeeping
  logic [vtr_pkg::SlotCount-1:0] taken_q;
  logic [SlotW-1:0] cnt_q, choose_q, best_slot_q;
  logic [IdxW-1:0]  best_idx_q;
  logic [31:0]      best_key_q, oldest_age_q, age;
  logic             best_found_q, evict_q;
  logic [6:0]       total_q;

  // staged and output result
  logic [2:0]       res_status_q;
  logic [SlotW-1:0] res_slot_q;
  logic [2:0]       res_mip_q;
  logic             res_valid_q, res_evict_q;
  logic [SlotW-1:0] res_slot_d;
  logic             out_valid_q;
  logic [2:0]       out_status_q, out_mip_q;
  logic [SlotW-1:0] out_slot_q;
  logic             out_entry_q, out_evict_q;
  logic [31:0]      out_key_q;
  logic [6:0]       out_total_q;

  assign pt_rd = vtr_pkg::page_entry_t'(pt_rdata);

  // index unit: the key shifted toward the level being probed, or the owner key as read
  always_comb begin
    c_sh = 4'(lvl_q - key_q[31:24]);
    if (cmd_i.calc_owner) begin
      c_mip = own_rdata[31:24];
      c_col = own_rdata[11:0];
      c_row = own_rdata[23:12];
    end else begin
      c_mip = lvl_q;
      c_col = key_q[11:0] >> c_sh;
      c_row = key_q[23:12] >> c_sh;
    end
    c_lvl  = c_mip[vtr_pkg::LvlW-1:0];
    c_side = vtr_pkg::side_at(c_lvl);
    c_ok   = (c_mip < 8'(vtr_pkg::MipLevels)) && (13'(c_col) < c_side)
             && (13'(c_row) < c_side);
    c_idx  = IdxW'(32'(vtr_pkg::level_base(c_lvl)) + 32'(c_row) * 32'(c_side)
                   + 32'(c_col));
  end

  // page table write port
  always_comb begin
    pt_we    = 1'b1;
    pt_waddr = idx_q;
    pt_wd    = pt_rd;
    case (cmd_i.pt_wr)
      vtr_pkg::PtClear: begin
        pt_waddr = clr_q;
        pt_wd    = '0;
      end
      vtr_pkg::PtFeedback: begin
        // a resident page keeps its pending mark as it is
        pt_wd.last_use = frame_q;
        pt_wd.pending  = pt_rd.pending | ~pt_rd.resident;
      end
      vtr_pkg::PtHit: begin
        pt_wd.last_use = frame_q;
        pt_wd.pending  = 1'b0;
      end
      vtr_pkg::PtFull: begin
        pt_waddr      = cur_idx_q;
        pt_wd         = ent_q;
        pt_wd.pending = 1'b0;
      end
      vtr_pkg::PtVictim: begin
        pt_waddr       = best_idx_q;
        pt_wd          = best_ent_q;
        pt_wd.resident = 1'b0;
      end
      vtr_pkg::PtPlace: begin
        pt_waddr = cur_idx_q;
        pt_wd    = '{last_use: frame_q, slot: choose_q, resident: 1'b1, pending: 1'b0};
      end
      default: pt_we = 1'b0;
    endcase
  end

  vtr_ram #(
    .Width(EntW),
    .Depth(vtr_pkg::TableDepth)
  ) u_page_table (
    .clk_i  (clk_i),
    .we_i   (pt_we),
    .waddr_i(pt_waddr),
    .wdata_i(pt_wd),
    .raddr_i(idx_q),
    .rdata_o(pt_rdata)
  );

  vtr_ram #(
    .Width(32),
    .Depth(vtr_pkg::SlotCount)
  ) u_slot_owner (
    .clk_i  (clk_i),
    .we_i   (cmd_i.pt_wr == vtr_pkg::PtPlace),
    .waddr_i(choose_q),
    .wdata_i(key_q),
    .raddr_i(cnt_q),
    .rdata_o(own_rdata)
  );

  assign age = frame_q - pt_rd.last_use;

  always_comb begin
    case (cmd_i.res_slot)
      vtr_pkg::SlotEntry:  res_slot_d = pt_rd.slot;
      vtr_pkg::SlotChosen: res_slot_d = choose_q;
      default:             res_slot_d = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      key_q    <= page_key_i;
      frame_q  <= frame_i;
      lvl_q    <= page_key_i[31:24];
    end else if (cmd_i.lvl_inc) begin
      lvl_q <= lvl_q + 8'd1;
    end
    if (cmd_i.calc_main || cmd_i.calc_owner) begin
      idx_q      <= c_idx;
      in_range_q <= c_ok;
    end
    if (cmd_i.cur_keep) begin
      cur_idx_q <= idx_q;
      ent_q     <= pt_rd;
    end
    if (cmd_i.choose_cnt)  choose_q <= cnt_q;
    if (cmd_i.choose_best) choose_q <= best_slot_q;
    if (cmd_i.best_upd) begin
      best_slot_q  <= cnt_q;
      best_idx_q   <= idx_q;
      best_ent_q   <= pt_rd;
      oldest_age_q <= age;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_slot_q   <= res_slot_d;
      res_mip_q    <= cmd_i.res_found ? lvl_q[2:0] : 3'd0;
      res_valid_q  <= cmd_i.res_found;
      res_evict_q  <= evict_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_mip_q    <= res_mip_q;
      out_entry_q  <= res_valid_q;
      out_evict_q  <= res_evict_q;
      out_key_q    <= res_evict_q ? best_key_q : 32'd0;
      out_total_q  <= total_q;
    end
  end

  // owner key of the current best candidate, captured from the owner read
  logic [31:0] own_key_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_owner) own_key_q <= own_rdata;
    if (cmd_i.best_upd)   best_key_q <= own_key_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      taken_q      <= '0;
      total_q      <= '0;
      cnt_q        <= '0;
      best_found_q <= 1'b0;
      evict_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.pt_wr == vtr_pkg::PtClear) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) begin
        best_found_q <= 1'b0;
        evict_q      <= 1'b0;
      end
      if (cmd_i.best_upd) best_found_q <= 1'b1;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.pt_wr == vtr_pkg::PtVictim) begin
        evict_q <= 1'b1;
        if (total_q != 7'd0) total_q <= total_q - 7'd1;
      end
      if (cmd_i.pt_wr == vtr_pkg::PtPlace) begin
        taken_q[choose_q] <= 1'b1;
        total_q           <= total_q + 7'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = (clr_q == IdxW'(vtr_pkg::TableDepth - 1));
    stat_o.action     = vtr_pkg::action_e'(action_q);
    stat_o.in_range   = in_range_q;
    stat_o.first_lvl  = (lvl_q == key_q[31:24]);
    stat_o.lvl_last   = (lvl_q >= 8'(vtr_pkg::MipLevels - 1));
    stat_o.resident   = pt_rd.resident;
    stat_o.pending    = pt_rd.pending;
    stat_o.taken_cur  = taken_q[cnt_q];
    stat_o.cnt_last   = (cnt_q == SlotW'(vtr_pkg::SlotCount - 1));
    // first eligible page always wins; later ones only when strictly older
    stat_o.older      = (pt_rd.last_use < frame_q) && (!best_found_q || age > oldest_age_q);
    stat_o.best_found = best_found_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign slot_index_o     = out_slot_q;
  assign slot_col_o       = 3'(out_slot_q % vtr_pkg::AtlasSide);
  assign slot_row_o       = 3'(out_slot_q / vtr_pkg::AtlasSide);
  assign found_mip_o      = out_mip_q;
  assign entry_valid_o    = out_entry_q;
  assign evicted_o        = out_evict_q;
  assign evicted_key_o    = out_key_q;
  assign resident_pages_o = out_total_q;

  // resident count tracks the taken slots whenever an item starts
  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> ($countones(taken_q) == 32'(total_q)))
    else $error("resident count and slot map disagree");

  // a placement never lands on a slot that still holds a page, unless it was just evicted
  a_place_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pt_wr == vtr_pkg::PtPlace && !evict_q) |-> !taken_q[choose_q])
    else $error("placement into a taken slot");

  a_victim_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pt_wr == vtr_pkg::PtVictim) |-> best_found_q)
    else $error("eviction without a candidate");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

>>> hw/rtl/virtual_texture_residency_unit.sv
`timescale 1ns / 1ps
// Virtual texture residency unit: mip-pyramid page table plus an 8x8 atlas of slots.
// Depends on vtr_pkg, vtr_ctrl, vtr_datapath (which holds the vtr_ram instances).
//
// Each input word is a feedback request, a page completion or a lookup, and
// every word except one with the unused action code gives exactly one result
// word. After reset the page table is swept clean, one entry a cycle, over
// all 21845 entries; in_ready_o stays low until that pass ends. After that the
// unit handles one word at a time. A feedback word or a key out of range
// passes through the index, read and use steps before its result is loaded,
// and the unit is ready for the next word in the cycle after the load. A
// lookup repeats the index, read and use steps for each mip level it probes,
// up to the coarsest level. A completion of a page that is not resident
// scans the slot map one slot a cycle for a free slot (up to all 64 slots);
// when the atlas is full it then walks all 64 slots again, each through an
// owner read, index, page table read and age compare. A finished result
// sits in an output register, so the next word is accepted while it waits.

module virtual_texture_residency_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] page_key_i,
  input  logic [31:0] frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_index_o,
  output logic [2:0]  slot_col_o,
  output logic [2:0]  slot_row_o,
  output logic [2:0]  found_mip_o,
  output logic        entry_valid_o,
  output logic        evicted_o,
  output logic [31:0] evicted_key_o,
  output logic [6:0]  resident_pages_o
);

  vtr_pkg::vtr_cmd_t  cmd;
  vtr_pkg::vtr_stat_t stat;

  // sequencer: owns the handshake on the input side
  vtr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // datapath: memories, scans and the output register
  vtr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (action_i),
    .page_key_i      (page_key_i),
    .frame_i         (frame_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .slot_col_o      (slot_col_o),
    .slot_row_o      (slot_row_o),
    .found_mip_o     (found_mip_o),
    .entry_valid_o   (entry_valid_o),
    .evicted_o       (evicted_o),
    .evicted_key_o   (evicted_key_o),
    .resident_pages_o(resident_pages_o)
  );

endmodule

>>> verif/virtual_texture_residency_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for virtual_texture_residency_unit: directed table, then random words.
// Depends on vtr_pkg and the RTL under hw/rtl; predicts every result word on its own.
module virtual_texture_residency_unit_test;

  localparam logic [1:0] ActUnused   = 2'd3;
  localparam int         WatchLimit  = 60000;  // covers the post-reset sweep
  localparam int         DrainCycles = 400;    // covers the worst completion
  localparam int         PoolSize    = 96;     // more keys than slots, forces eviction
  localparam int         ExpDepth    = 64;     // expected words in flight, ring buffer

  typedef struct packed {
    vtr_pkg::status_e status;
    logic [5:0]  slot_index;
    logic [2:0]  slot_col;
    logic [2:0]  slot_row;
    logic [2:0]  found_mip;
    logic        entry_valid;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [6:0]  resident_pages;
  } result_t;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] key;
    logic [31:0] frame;
    bit          typed;  // expectation written in the row
    vtr_pkg::status_e st;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [31:0] page_key_i = '0;
  logic [31:0] frame_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [5:0]  slot_index_o;
  logic [2:0]  slot_col_o;
  logic [2:0]  slot_row_o;
  logic [2:0]  found_mip_o;
  logic        entry_valid_o;
  logic        evicted_o;
  logic [31:0] evicted_key_o;
  logic [6:0]  resident_pages_o;

  virtual_texture_residency_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the page table and atlas.
  logic [31:0] pg_last_use [vtr_pkg::TableDepth];
  logic [5:0]  pg_slot     [vtr_pkg::TableDepth];
  bit          pg_resident [vtr_pkg::TableDepth];
  bit          pg_pending  [vtr_pkg::TableDepth];
  bit          atlas_taken [vtr_pkg::SlotCount];
  logic [31:0] atlas_owner [vtr_pkg::SlotCount];
  int unsigned live_pages;

  result_t     exp_words [ExpDepth];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          errors;
  int          idle_cycles;
  bit          cur_typed = 1'b0;
  vtr_pkg::status_e cur_typed_st = vtr_pkg::StRange;
  int          send_gap_pct = 0;   // sender idle chance per word
  int          stall_pct = 0;      // receiver stall chance per cycle
  logic [31:0] key_pool [PoolSize];

  function automatic bit key_ok(input logic [31:0] key, output int unsigned idx);
    int unsigned mip, col, row, side, base;
    mip = 32'(key[31:24]);
    row = 32'(key[23:12]);
    col = 32'(key[11:0]);
    idx = 0;
    if (mip >= vtr_pkg::MipLevels) return 1'b0;
    side = vtr_pkg::VirtSide >> mip;
    if (col >= side || row >= side) return 1'b0;
    base = 0;
    for (int unsigned m = 0; m < mip; m++)
      base += (vtr_pkg::VirtSide >> m) * (vtr_pkg::VirtSide >> m);
    idx = base + row * side + col;
    return 1'b1;
  endfunction

  function automatic void put_slot(inout result_t r, input int unsigned s);
    r.slot_index = 6'(s);
    r.slot_col   = 3'(s % vtr_pkg::AtlasSide);
    r.slot_row   = 3'(s / vtr_pkg::AtlasSide);
  endfunction

  // Advances the shadow state by one word; returns 0 for the unused action.
  function automatic bit resolve_word(input logic [1:0] act, input logic [31:0] key,
                                      input logic [31:0] frame, output result_t r);
    int unsigned idx, oidx, mip, col, row, side, cidx;
    int          chosen;
    logic [31:0] top_age, age;
    r = '0;
    r.status = vtr_pkg::StRange;
    if (act == ActUnused) return 1'b0;
    if (!key_ok(key, idx)) begin
      r.status = vtr_pkg::StRange;
    end else if (act == vtr_pkg::ActFeedback) begin
      pg_last_use[idx] = frame;
      if (pg_resident[idx] || pg_pending[idx]) begin
        r.status = vtr_pkg::StKnown;
      end else begin
        pg_pending[idx] = 1'b1;
        r.status = vtr_pkg::StRequested;
      end
    end else if (act == vtr_pkg::ActComplete) begin
      pg_pending[idx] = 1'b0;
      if (pg_resident[idx]) begin
        pg_last_use[idx] = frame;
        r.status = vtr_pkg::StKnown;
        put_slot(r, 32'(pg_slot[idx]));
      end else begin
        chosen = -1;
        for (int s = 0; s < vtr_pkg::SlotCount; s++) begin
          if (!atlas_taken[s]) begin
            chosen = s;
            break;
          end
        end
        if (chosen < 0) begin
          // LRU among pages not touched this frame; strict compare keeps lowest slot
          top_age = '0;
          for (int s = 0; s < vtr_pkg::SlotCount; s++) begin
            if (!key_ok(atlas_owner[s], oidx)) continue;
            if (pg_last_use[oidx] >= frame) continue;
            age = frame - pg_last_use[oidx];
            if (age > top_age) begin
              top_age = age;
              chosen = s;
            end
          end
          if (chosen >= 0) begin
            if (key_ok(atlas_owner[chosen], oidx)) pg_resident[oidx] = 1'b0;
            if (live_pages > 0) live_pages--;
            r.evicted = 1'b1;
            r.evicted_key = atlas_owner[chosen];
          end
        end
        if (chosen < 0) begin
          r.status = vtr_pkg::StFull;
        end else begin
          atlas_taken[chosen] = 1'b1;
          atlas_owner[chosen] = key;
          pg_resident[idx] = 1'b1;
          pg_slot[idx] = 6'(chosen);
          pg_last_use[idx] = frame;
          live_pages++;
          r.status = vtr_pkg::StPlaced;
          put_slot(r, chosen);
        end
      end
    end else begin
      // walk toward coarser mips until a resident ancestor turns up
      r.status = vtr_pkg::StLookup;
      mip = 32'(key[31:24]);
      row = 32'(key[23:12]);
      col = 32'(key[11:0]);
      for (int unsigned m = mip; m < vtr_pkg::MipLevels; m++) begin
        side = vtr_pkg::VirtSide >> m;
        if ((col >> (m - mip)) >= side || (row >> (m - mip)) >= side) continue;
        void'(key_ok({8'(m), 12'(row >> (m - mip)), 12'(col >> (m - mip))}, cidx));
        if (pg_resident[cidx]) begin
          put_slot(r, 32'(pg_slot[cidx]));
          r.found_mip = 3'(m);
          r.entry_valid = 1'b1;
          break;
        end
      end
    end
    r.resident_pages = 7'(live_pages);
    return 1'b1;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 40) $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
  endtask

  // Monitor: handshakes are seen at the edge with pre-edge values.
  always @(posedge clk_i) begin
    result_t r, w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o && resolve_word(action_i, page_key_i, frame_i, r)) begin
        if (cur_typed) begin
          r = '0;
          r.status = cur_typed_st;
        end
        exp_words[exp_wr % ExpDepth] = r;
        exp_wr++;
      end
      if (out_valid_o && out_ready_i) begin
        if (exp_wr == exp_rd) begin
          report("unexpected word", {29'd0, status_o}, '0);
        end else begin
          w = exp_words[exp_rd % ExpDepth];
          exp_rd++;
          if (status_o != w.status) report("status", 32'(status_o), 32'(w.status));
          if (slot_index_o != w.slot_index)
            report("slot_index", 32'(slot_index_o), 32'(w.slot_index));
          if (slot_col_o != w.slot_col) report("slot_col", 32'(slot_col_o), 32'(w.slot_col));
          if (slot_row_o != w.slot_row) report("slot_row", 32'(slot_row_o), 32'(w.slot_row));
          if (found_mip_o != w.found_mip)
            report("found_mip", 32'(found_mip_o), 32'(w.found_mip));
          if (entry_valid_o != w.entry_valid)
            report("entry_valid", 32'(entry_valid_o), 32'(w.entry_valid));
          if (evicted_o != w.evicted) report("evicted", 32'(evicted_o), 32'(w.evicted));
          if (evicted_key_o != w.evicted_key) report("evicted_key", evicted_key_o, w.evicted_key);
          if (resident_pages_o != w.resident_pages)
            report("resident_pages", 32'(resident_pages_o), 32'(w.resident_pages));
        end
      end
    end
  end

  // Receiver back-pressure, one decision per cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long with no word moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one word and hold it until taken. Ready is sampled mid-cycle.
  task automatic send_word(input stim_t s);
    action_i     <= s.act;
    page_key_i   <= s.key;
    frame_i      <= s.frame;
    cur_typed    <= s.typed;
    cur_typed_st <= s.st;
    in_valid_i   <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] valid_key();
    int unsigned mip, side;
    mip = ($urandom_range(3) == 0) ? $urandom_range(vtr_pkg::MipLevels - 1)
                                   : $urandom_range(2);
    side = vtr_pkg::VirtSide >> mip;
    return {8'(mip), 12'($urandom_range(side - 1)), 12'($urandom_range(side - 1))};
  endfunction

  stim_t directed[] = '{
    // right after reset: nothing resident, nothing in the atlas
    '{vtr_pkg::ActLookup,   32'h0000_0000, 32'd0,         1'b1, vtr_pkg::StLookup},
    '{vtr_pkg::ActFeedback, 32'h0800_0000, 32'd0,         1'b1, vtr_pkg::StRange},  // mip too big
    '{vtr_pkg::ActComplete, 32'h0000_0080, 32'd0,         1'b1, vtr_pkg::StRange},  // column past edge
    '{vtr_pkg::ActLookup,   32'h0700_1000, 32'd0,         1'b1, vtr_pkg::StRange},  // row past edge
    '{vtr_pkg::ActFeedback, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, vtr_pkg::StRange},
    '{ActUnused,            32'h0000_0000, 32'd0,         1'b0, vtr_pkg::StRange},  // no result
    '{vtr_pkg::ActFeedback, 32'h0000_0000, 32'd1,         1'b0, vtr_pkg::StRange},
    '{vtr_pkg::ActFeedback, 32'h0000_0000, 32'd1,         1'b0, vtr_pkg::StRange},  // already pending
    '{vtr_pkg::ActComplete, 32'h0000_0000, 32'd1,         1'b0, vtr_pkg::StRange},
    '{vtr_pkg::ActComplete, 32'h0000_0000, 32'd2,         1'b0, vtr_pkg::StRange},  // already resident
    '{vtr_pkg::ActFeedback, 32'h0000_0000, 32'd2,         1'b0, vtr_pkg::StRange},
    '{vtr_pkg::ActLookup,   32'h0000_1001, 32'd2,         1'b0, vtr_pkg::StRange},  // no cover yet
    '{vtr_pkg::ActComplete, 32'h0700_0000, 32'd3,         1'b0, vtr_pkg::StRange},  // never requested
    '{vtr_pkg::ActLookup,   32'h0000_1001, 32'd3,         1'b0, vtr_pkg::StRange},  // covered at top mip
    '{vtr_pkg::ActComplete, 32'h0007_F07F, 32'hFFFF_FFFF, 1'b0, vtr_pkg::StRange},  // far corner
    '{vtr_pkg::ActLookup,   32'h0007_F07F, 32'hFFFF_FFFF, 1'b0, vtr_pkg::StRange},
    '{vtr_pkg::ActComplete, 32'h0600_1001, 32'd4,         1'b0, vtr_pkg::StRange},
    '{vtr_pkg::ActLookup,   32'h0500_3003, 32'd4,         1'b0, vtr_pkg::StRange},
    '{ActUnused,            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, vtr_pkg::StRange}
  };

  initial begin
    stim_t       s;
    logic [31:0] cur_frame;
    int          pick;
    int          r;
    errors = 0;
    idle_cycles = 0;
    live_pages = 0;
    for (int i = 0; i < vtr_pkg::TableDepth; i++) begin
      pg_last_use[i] = '0;
      pg_slot[i] = '0;
      pg_resident[i] = 1'b0;
      pg_pending[i] = 1'b0;
    end
    for (int i = 0; i < vtr_pkg::SlotCount; i++) begin
      atlas_taken[i] = 1'b0;
      atlas_owner[i] = '0;
    end
    for (int i = 0; i < PoolSize; i++) key_pool[i] = valid_key();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_word(directed[i]);
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    cur_frame = 32'd10;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 67; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 67; end
        default: begin send_gap_pct = 29; stall_pct = 29; end
      endcase
      // phase 2 starts right before the frame counter wraps
      if (phase == 2) cur_frame = 32'hFFFF_FFF8;
      for (int n = 0; n < 290; n++) begin
        r = $urandom_range(99);
        if (r < 6) cur_frame = cur_frame + 1;
        else if (r == 6 && phase != 2) cur_frame = $urandom;
        s.typed = 1'b0;
        s.st = vtr_pkg::StRange;
        s.frame = cur_frame;
        pick = $urandom_range(PoolSize - 1);
        r = $urandom_range(99);
        if (r < 38) begin
          s.act = vtr_pkg::ActFeedback; s.key = key_pool[pick];
        end else if (r < 74) begin
          s.act = vtr_pkg::ActComplete; s.key = key_pool[pick];
        end else if (r < 92) begin
          s.act = vtr_pkg::ActLookup; s.key = ($urandom_range(1)) ? key_pool[pick] : valid_key();
        end else begin
          // noise: raw keys and frames, any action code
          s.act = 2'($urandom_range(3)); s.key = $urandom; s.frame = $urandom;
          if (s.act == ActUnused) n--;
        end
        send_word(s);
      end
      // pause the sender until the unit has drained
      in_valid_i <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (exp_wr != exp_rd) report("words never returned", 32'(exp_wr - exp_rd), '0);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/vtr_pkg.sv
hw/rtl/vtr_ram.sv
hw/rtl/vtr_ctrl.sv
hw/rtl/vtr_datapath.sv
hw/rtl/virtual_texture_residency_unit.sv
verif/virtual_texture_residency_unit_test.sv
